// ----- hdl/utf8_to_utf16_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Shared property macros for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8u16 check failed in the same cycle");

`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8u16 check failed in the following cycle");

`else

`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    localparam int unsigned MaxUnits = 3;

    localparam logic [15:0] ReplacementUnit   = 16'hFFFD;
    localparam logic [20:0] SupplementaryBase = 21'h10000;
    localparam logic [15:0] HighSurrogateBase = 16'hD800;
    localparam logic [15:0] LowSurrogateBase  = 16'hDC00;
    localparam logic [15:0] TerminatorUnit    = 16'h0000;

    // Units produced by one input byte, in emission order.
    typedef struct packed {
        logic [1:0]                 cnt;
        logic [MaxUnits-1:0][15:0]  unit;
        logic [MaxUnits-1:0]        term;
    } t_group;

endpackage

`default_nettype wire

// ----- hdl/u8u16_stream_if.sv -----
// ----------------------------------------------------------------------------
// u8u16 stream interfaces
// Valid/ready channels for UTF-8 bytes in and UTF-16 code units out.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_terminator;

    modport source (output valid, output code_unit, output is_terminator, input ready);
    modport sink (input valid, input code_unit, input is_terminator, output ready);
endinterface

`default_nettype wire

// ----- hdl/utf8_to_utf16_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 transcoder with a closing terminator unit.
// ----------------------------------------------------------------------------
// The input channel carries one UTF-8 byte per transaction, with last_byte set
// on the final byte of a string. The output channel carries one UTF-16 code
// unit per transaction; is_terminator marks the zero unit that closes a string.
// A byte enters an input register, is decoded from there and its units are
// loaded into a three-entry result buffer once the buffer can take them. The
// first unit of a byte is then offered from the head of that buffer.
// The block takes one byte per cycle while the receiver is ready, as long as
// each byte yields at most one unit. A byte that completes a supplementary
// code point, or a last byte that adds a terminator, holds the input while
// the result buffer drains, one unit per cycle while the receiver is ready.
// Reset clears the input register, the buffer and any pending sequence.
// When the receiver stalls, the buffer and then the input register fill and
// ready drops; no transaction is lost.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_to_utf16_decoder_defines.svh"

module utf8_to_utf16_decoder
    import u8u16_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u8u16_byte_if.sink  i_byte,
    u8u16_unit_if.source o_unit
);

    logic                      r_in_vld;
    logic [7:0]                r_in_byte;
    logic                      r_in_last;
    logic [1:0]                r_cnt;
    logic [1:0]                n_cnt;
    logic [MaxUnits-1:0][15:0] r_unit;
    logic [MaxUnits-1:0][15:0] n_unit;
    logic [MaxUnits-1:0]       r_term;
    logic [MaxUnits-1:0]       n_term;
    logic                      w_load;
    logic                      w_pop;
    t_group                    w_grp;

    assign w_pop  = (r_cnt != 2'd0) && o_unit.ready;
    assign w_load = r_in_vld && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_unit.ready));
    assign i_byte.ready = !r_in_vld || w_load;

    assign o_unit.valid         = (r_cnt != 2'd0);
    assign o_unit.code_unit     = r_unit[0];
    assign o_unit.is_terminator = r_term[0];

    u8u16_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_load),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_grp   (w_grp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.byte_in;
            r_in_last <= i_byte.last_byte;
        end
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_unit = r_unit;
        n_term = r_term;
        if (w_load) begin
            n_cnt  = w_grp.cnt;
            n_unit = w_grp.unit;
            n_term = w_grp.term;
        end else if (w_pop) begin
            n_cnt  = r_cnt - 2'd1;
            n_unit = {16'd0, r_unit[MaxUnits-1:1]};
            n_term = {1'b0, r_term[MaxUnits-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit <= n_unit;
        r_term <= n_term;
    end

    `U8U16_ASSERT_NOW(a_term_is_final, i_clk, i_rst_n,
        r_cnt != 2'd0 && r_term[0], r_cnt == 2'd1)
    `U8U16_ASSERT_NEXT(a_last_gives_output, i_clk, i_rst_n,
        w_load && r_in_last, r_cnt != 2'd0)
    `U8U16_ASSERT_NOW(a_term_unit_zero, i_clk, i_rst_n,
        r_cnt != 2'd0 && r_term[0], r_unit[0] == TerminatorUnit)

endmodule

`default_nettype wire

// ----- hdl/u8u16_decode.sv -----
// ----------------------------------------------------------------------------
// u8u16_decode
// Holds the sequence state and turns one byte into a group of up to three
// UTF-16 code units.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_decode
    import u8u16_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_group          o_grp
);

    logic [1:0]  r_exp;
    logic [1:0]  n_exp;
    logic [20:0] r_acc;
    logic [20:0] n_acc;
    logic [20:0] w_acc_sh;
    logic [20:0] w_cp_off;
    logic [1:0]  w_nd;
    logic [15:0] w_u0;
    logic [15:0] w_u1;

    assign w_acc_sh = {r_acc[14:0], i_byte[5:0]};
    assign w_cp_off = w_acc_sh - SupplementaryBase;

    always_comb begin
        n_exp = r_exp;
        n_acc = r_acc;
        w_nd  = 2'd0;
        w_u0  = '0;
        w_u1  = '0;
        if (r_exp != 2'd0) begin
            if (i_byte[7:6] != 2'b10) begin
                w_nd  = 2'd1;
                w_u0  = ReplacementUnit;
                n_exp = 2'd0;
            end else begin
                n_acc = w_acc_sh;
                n_exp = r_exp - 2'd1;
                if (r_exp == 2'd1) begin
                    if (w_acc_sh[20:16] != 5'd0) begin
                        w_nd = 2'd2;
                        w_u0 = HighSurrogateBase + {6'd0, w_cp_off[19:10]};
                        w_u1 = LowSurrogateBase + {6'd0, w_cp_off[9:0]};
                    end else begin
                        w_nd = 2'd1;
                        w_u0 = w_acc_sh[15:0];
                    end
                end
            end
        end else begin
            case (i_byte) inside
                [8'h00:8'h7F]: begin
                    w_nd = 2'd1;
                    w_u0 = {8'd0, i_byte};
                end
                [8'hC0:8'hDF]: begin
                    n_exp = 2'd1;
                    n_acc = {16'd0, i_byte[4:0]};
                end
                [8'hE0:8'hEF]: begin
                    n_exp = 2'd2;
                    n_acc = {17'd0, i_byte[3:0]};
                end
                [8'hF0:8'hF7]: begin
                    n_exp = 2'd3;
                    n_acc = {18'd0, i_byte[2:0]};
                end
                default: begin
                end
            endcase
        end

        o_grp         = '0;
        o_grp.unit[0] = w_u0;
        o_grp.unit[1] = w_u1;
        o_grp.cnt     = w_nd;
        if (i_last) begin
            n_exp            = 2'd0;
            n_acc            = '0;
            o_grp.unit[w_nd] = TerminatorUnit;
            o_grp.term[w_nd] = 1'b1;
            o_grp.cnt        = w_nd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
            r_acc <= '0;
        end else if (i_adv) begin
            r_exp <= n_exp;
            r_acc <= n_acc;
        end
    end

    `U8U16_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, i_adv && i_last,
        r_exp == 2'd0 && r_acc == 21'd0)
    `U8U16_ASSERT_NOW(a_ascii_one_unit, i_clk, i_rst_n,
        i_adv && !i_last && r_exp == 2'd0 && !i_byte[7], o_grp.cnt == 2'd1)
    `U8U16_ASSERT_NOW(a_lead_no_unit, i_clk, i_rst_n,
        r_exp == 2'd0 && i_byte[7:6] == 2'b11 && !i_last, o_grp.cnt == 2'd0)

endmodule

`default_nettype wire

// ----- sim/utf8_to_utf16_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_test
// Drives UTF-8 strings into the decoder and checks every UTF-16 unit that
// comes out against a software decoder kept in step with the accepted bytes.
// Directed strings cover the byte classes, surrogate pairs, broken sequences
// and terminators; random strings mix valid characters with noise under
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------

module utf8_to_utf16_decoder_test;
    import u8u16_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 20;
    localparam int MaxGap      = 18;
    localparam int RandomBytes = 250;

    typedef struct packed {
        logic [15:0] unit;
        logic        term;
    } t_utf16_unit;

    logic i_clk;
    logic i_rst_n;

    u8u16_byte_if byte_ch ();
    u8u16_unit_if unit_ch ();

    utf8_to_utf16_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_unit  (unit_ch)
    );

    t_utf16_unit expected_units[$];
    logic [1:0]  pending_cont;
    logic [20:0] code_point_acc;
    int          error_count;
    int          bytes_sent;
    int          cycle_count;
    int          hold_cycles;
    bit          idle_on;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    function automatic void push_unit(input logic [15:0] unit, input logic term);
        t_utf16_unit u;
        u.unit = unit;
        u.term = term;
        expected_units.push_back(u);
    endfunction

    function automatic void predict_units(input logic [7:0] b, input logic last);
        logic [20:0] cp;
        if (pending_cont != 2'd0) begin
            if (b[7:6] != 2'b10) begin
                push_unit(ReplacementUnit, 1'b0);
                pending_cont = 2'd0;
            end else begin
                code_point_acc = {code_point_acc[14:0], b[5:0]};
                pending_cont = pending_cont - 2'd1;
                if (pending_cont == 2'd0) begin
                    cp = code_point_acc;
                    if (cp >= SupplementaryBase) begin
                        cp = cp - SupplementaryBase;
                        push_unit(HighSurrogateBase + {6'd0, cp[19:10]}, 1'b0);
                        push_unit(LowSurrogateBase + {6'd0, cp[9:0]}, 1'b0);
                    end else begin
                        push_unit(cp[15:0], 1'b0);
                    end
                end
            end
        end else begin
            if (!b[7]) begin
                push_unit({8'd0, b}, 1'b0);
            end else if (b[7:5] == 3'b110) begin
                pending_cont = 2'd1;
                code_point_acc = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                pending_cont = 2'd2;
                code_point_acc = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                pending_cont = 2'd3;
                code_point_acc = {18'd0, b[2:0]};
            end
        end
        if (last) begin
            pending_cont = 2'd0;
            code_point_acc = 21'd0;
            push_unit(TerminatorUnit, 1'b1);
        end
    endfunction

    function automatic void check_unit(input logic [15:0] unit, input logic term);
        t_utf16_unit want;
        if (expected_units.size() == 0) begin
            if (error_count < 10) begin
                $display("Unexpected unit %h term %b at cycle %0d", unit, term, cycle_count);
            end
            error_count++;
        end else begin
            want = expected_units.pop_front();
            if (unit !== want.unit || term !== want.term) begin
                if (error_count < 10) begin
                    $display("Unit mismatch at cycle %0d: expected %h term %b, got %h term %b",
                             cycle_count, want.unit, want.term, unit, term);
                end
                error_count++;
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, MaxGap) : 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.byte_in   <= b;
        byte_ch.last_byte <= last;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        predict_units(b, last);
        bytes_sent++;
    endtask

    task automatic send_random_string(input int n_chars);
        logic [7:0] bytes_q[$];
        int         kind;
        int         len;
        int         keep;
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            case (len)
                1: bytes_q.push_back({1'b0, 7'($urandom)});
                2: bytes_q.push_back({3'b110, 5'($urandom)});
                3: bytes_q.push_back({4'b1110, 4'($urandom)});
                default: bytes_q.push_back({5'b11110, 3'($urandom)});
            endcase
            if (kind < 70) begin
                keep = len - 1;
            end else if (kind < 85) begin
                keep = 0;
                bytes_q[bytes_q.size() - 1] = 8'($urandom_range(0, 255));
            end else begin
                keep = (len > 1) ? $urandom_range(0, len - 2) : 0;
            end
            for (int k = 0; k < keep; k++) begin
                bytes_q.push_back({2'b10, 6'($urandom)});
            end
        end
        foreach (bytes_q[i]) begin
            send_byte(bytes_q[i], i == bytes_q.size() - 1);
        end
    endtask

    task automatic test_ascii_and_zero();
        idle_on = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h0A, 1'b1);
    endtask

    task automatic test_multibyte();
        idle_on = 1'b0;
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // The largest 4-byte payload wraps inside the surrogate fields.
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_skipped_bytes();
        idle_on = 1'b1;
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_broken_sequence();
        idle_on = 1'b1;
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_last_byte_cases();
        idle_on = 1'b0;
        send_byte(8'hE2, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b1);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hC5, 1'b0);
        send_byte(8'hC5, 1'b1);
        send_byte(8'hBF, 1'b1);
        send_byte(8'h7E, 1'b1);
    endtask

    task automatic test_backpressure();
        int start;
        idle_on = 1'b0;
        hold_cycles = 150;
        start = bytes_sent;
        while (bytes_sent - start < 40) begin
            send_random_string($urandom_range(2, 8));
        end
    endtask

    task automatic test_random_strings();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RandomBytes) begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_random_string($urandom_range(1, 10));
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("utf8_to_utf16_decoder_test failed");
        $finish;
    end

    initial begin
        int stall;
        unit_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, MaxGap) : 0;
            end
            if (stall > 0) begin
                unit_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            unit_ch.ready <= 1'b1;
            do @(posedge i_clk); while (unit_ch.valid !== 1'b1);
            check_unit(unit_ch.code_unit, unit_ch.is_terminator);
        end
    end

    initial begin
        error_count       = 0;
        bytes_sent        = 0;
        hold_cycles       = 0;
        idle_on           = 1'b0;
        pending_cont      = 2'd0;
        code_point_acc    = 21'd0;
        i_rst_n           <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.byte_in   <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii_and_zero();
        test_multibyte();
        test_skipped_bytes();
        test_broken_sequence();
        test_last_byte_cases();
        test_backpressure();
        test_random_strings();

        byte_ch.valid <= 1'b0;
        wait (expected_units.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (error_count == 0 && expected_units.size() == 0) begin
            $display("utf8_to_utf16_decoder_test passed");
        end else begin
            $display("utf8_to_utf16_decoder_test failed");
        end
        $finish;
    end

endmodule
